FILE: rtl/ptb_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the periodic timer bank.
// No dependencies; used by the request interface and the top level.
package ptb_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned IndexW = 8;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [CountW-1:0] TickStep = CountW'(1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	// One timer as held in the state memory
	typedef struct packed {
		logic [CountW-1:0] interval;
		logic [CountW-1:0] remaining;
		logic              flag;
	} entry_t;

endpackage

FILE: rtl/ptb_req_if.sv
`timescale 1ns / 1ps
// Request channel of the periodic timer bank: valid, ready and one command.
// Depends on ptb_pkg for field widths.
interface ptb_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     op;
	logic [ptb_pkg::IndexW-1:0]     timer_index;
	logic [ptb_pkg::CountW-1:0]     period;

	modport source (output valid, op, timer_index, period, input ready);
	modport sink (input valid, op, timer_index, period, output ready);
endinterface

FILE: rtl/ptb_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the periodic timer bank: valid, ready and the expiry bit.
// No dependencies.
interface ptb_rsp_if;
	logic valid;
	logic ready;
	logic expired;

	modport source (output valid, expired, input ready);
	modport sink (input valid, expired, output ready);
endinterface

FILE: rtl/periodic_timer_bank_top.sv
`timescale 1ns / 1ps
// Top level of the periodic timer bank: sequencer, timer state memory, output register.
// Depends on ptb_pkg, ptb_req_if and ptb_rsp_if.
//
//  channel | dir | payload                      | transfer when
//  --------+-----+------------------------------+--------------------
//  req     | in  | op, timer_index, period      | req.valid & req.ready
//  rsp     | out | expired                      | rsp.valid & rsp.ready
//
// Tick and start load the output register on accept, as do stop and query at an index
// outside the bank when no ticks are pending. Stop, and a query with no pending ticks,
// at an index in the bank go through accept, read, write back and output. A query with
// pending ticks first walks the timer memory through its single read port, then reads,
// writes back and outputs, or goes straight to output at an index outside the bank.
// Reset clears the pending count and the per-timer valid bits; memory is not swept.
// A stalled rsp holds the result in its register; req is refused until it can go.
module periodic_timer_bank_top #(
	parameter int unsigned TIMER_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ptb_req_if.sink    req,
	ptb_rsp_if.source  rsp
);

	localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RD     = 6'b000010,
		S_WB     = 6'b000100,
		S_SWEEP  = 6'b001000,
		S_SWLAST = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q;
	logic [ptb_pkg::CountW-1:0] pend_q;
	logic [TIMER_COUNT-1:0]     vld_q;
	logic [IdxW-1:0]            idx_q;
	logic                       in_range_q;
	logic [1:0]                 op_q;
	logic                       res_q;
	logic [IdxW-1:0]            cnt_q;
	logic                       sw_vld_s1;
	logic [IdxW-1:0]            sw_addr_s1;
	logic                       out_valid_q;
	logic                       exp_q;

	ptb_pkg::entry_t mem [TIMER_COUNT];
	ptb_pkg::entry_t rd_q;

	logic            mem_we;
	logic [IdxW-1:0] mem_waddr;
	ptb_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [IdxW-1:0] mem_raddr;

	logic            out_free;
	logic            accept;
	logic            req_in_range;
	logic [IdxW-1:0] req_idx;
	logic            load_out;
	logic            load_val;

	ptb_pkg::entry_t sw_new;
	logic            sw_write;
	ptb_pkg::entry_t wb_new;
	logic            wb_write;
	logic            wb_res;
	logic            wb_vld;

	assign out_free     = !out_valid_q || rsp.ready;
	assign req.ready    = (state_q == S_IDLE) && out_free;
	assign accept       = req.valid && req.ready;
	assign req_in_range = {1'b0, req.timer_index} < 9'(TIMER_COUNT);
	assign req_idx      = req.timer_index[IdxW-1:0];

	// Apply the pending count to the timer read back during the sweep
	always_comb begin
		sw_new   = rd_q;
		sw_write = vld_q[sw_addr_s1] && (rd_q.interval != '0);
		if (rd_q.remaining <= pend_q) begin
			sw_new.remaining = rd_q.interval;
			sw_new.flag      = 1'b1;
		end else begin
			sw_new.remaining = rd_q.remaining - pend_q;
		end
	end

	// Stop clears the interval; query reports and clears the flag
	always_comb begin
		wb_vld   = vld_q[idx_q];
		wb_new   = rd_q;
		wb_res   = 1'b0;
		wb_write = 1'b0;
		if (op_q == ptb_pkg::OP_STOP) begin
			wb_new.interval = '0;
			wb_write        = wb_vld;
		end else begin
			wb_res      = wb_vld && rd_q.flag;
			wb_new.flag = 1'b0;
			wb_write    = wb_res;
		end
	end

	// Memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = wb_new;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		load_out  = 1'b0;
		load_val  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && req.op == ptb_pkg::OP_START && req_in_range) begin
					mem_we    = 1'b1;
					mem_waddr = req_idx;
					mem_wdata = '{interval: req.period, remaining: req.period, flag: 1'b0};
				end
				if (accept) begin
					if (req.op == ptb_pkg::OP_TICK || req.op == ptb_pkg::OP_START) begin
						load_out = 1'b1;
					end else if (req.op == ptb_pkg::OP_STOP) begin
						load_out = !req_in_range;
					end else begin
						load_out = (pend_q == '0) && !req_in_range;
					end
				end
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			S_WB: begin
				mem_we = wb_write;
			end
			S_SWEEP: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
				mem_we    = sw_vld_s1 && sw_write;
				mem_waddr = sw_addr_s1;
				mem_wdata = sw_new;
			end
			S_SWLAST: begin
				mem_we    = sw_vld_s1 && sw_write;
				mem_waddr = sw_addr_s1;
				mem_wdata = sw_new;
			end
			S_OUT: begin
				load_out = out_free;
				load_val = res_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Timer state memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Command fields held for the multi-cycle ops
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q      <= req_idx;
			in_range_q <= req_in_range;
			op_q       <= req.op;
		end
		if (state_q == S_WB) begin
			res_q <= wb_res;
		end else if (state_q == S_SWLAST) begin
			res_q <= 1'b0;
		end
		sw_addr_s1 <= cnt_q;
	end

	// Sequencer, pending count, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= '0;
			vld_q       <= '0;
			cnt_q       <= '0;
			sw_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			exp_q       <= 1'b0;
		end else begin
			sw_vld_s1 <= (state_q == S_SWEEP);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							ptb_pkg::OP_TICK: begin
								if (pend_q != ptb_pkg::CountMax) begin
									pend_q <= pend_q + ptb_pkg::TickStep;
								end
							end
							ptb_pkg::OP_START: begin
								if (req_in_range) begin
									vld_q[req_idx] <= 1'b1;
								end
							end
							ptb_pkg::OP_STOP: begin
								if (req_in_range) begin
									state_q <= S_RD;
								end
							end
							default: begin
								cnt_q <= '0;
								if (pend_q != '0) begin
									state_q <= S_SWEEP;
								end else if (req_in_range) begin
									state_q <= S_RD;
								end
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_OUT;
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + IdxW'(1);
					if (cnt_q == LastIdx) begin
						state_q <= S_SWLAST;
					end
				end
				S_SWLAST: begin
					pend_q  <= '0;
					state_q <= in_range_q ? S_RD : S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Hold the result until the transfer completes
			if (load_out) begin
				out_valid_q <= 1'b1;
				exp_q       <= load_val;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.expired = exp_q;

endmodule
